@@ src/clfe_pkg.sv @@
// Shared types and constants for the content-length frame extractor.
// Holds the header key text, the terminator bytes and the result record.
// No dependencies.
`default_nettype none

package clfe_pkg;

	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_SP  = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_D0  = 8'h30;
	localparam logic [7:0] CHAR_D9  = 8'h39;

	// length of the key text "Content-Length:"
	localparam logic [3:0] KEY_LEN = 4'd15;

	typedef struct packed {
		logic       produce;
		logic [7:0] payload_byte;
		logic       last_of_message;
		logic       empty_message;
	} result_t;

	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h43; // C
			4'd1:    c = 8'h6F; // o
			4'd2:    c = 8'h6E; // n
			4'd3:    c = 8'h74; // t
			4'd4:    c = 8'h65; // e
			4'd5:    c = 8'h6E; // n
			4'd6:    c = 8'h74; // t
			4'd7:    c = 8'h2D; // -
			4'd8:    c = 8'h4C; // L
			4'd9:    c = 8'h65; // e
			4'd10:   c = 8'h6E; // n
			4'd11:   c = 8'h67; // g
			4'd12:   c = 8'h74; // t
			4'd13:   c = 8'h68; // h
			4'd14:   c = 8'h3A; // :
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// CR LF CR LF: even positions are CR, odd positions LF
	function automatic logic [7:0] brk_char(input logic [1:0] idx);
		return idx[0] ? CHAR_LF : CHAR_CR;
	endfunction

endpackage

`default_nettype wire

@@ src/clfe_hdr_scan.sv @@
// Header scanner and payload counter of the content-length frame extractor.
// Holds the per-stream state and turns one byte into zero or one result.
// Depends on clfe_pkg.
`default_nettype none

module clfe_hdr_scan #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [7:0]         rx_byte,
	output clfe_pkg::result_t       res
);

	localparam int LW = LENGTH_BITS;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_BLANK = 4'b0010,
		PH_DIGIT = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	logic          in_payload_q, in_payload_n;
	logic [1:0]    brk_q, brk_n;
	logic [3:0]    key_q, key_n, key_try;
	phase_t        phase_q, phase_n;
	logic [LW-1:0] len_q, len_n, len_dig;
	logic [LW-1:0] rem_q, rem_n;
	logic [LW+3:0] prod;
	logic          is_digit, is_blank, key_hit, brk_hit, last, have_len;

	assign is_digit = rx_byte inside {[clfe_pkg::CHAR_D0 : clfe_pkg::CHAR_D9]};
	assign is_blank = rx_byte inside {clfe_pkg::CHAR_SP, clfe_pkg::CHAR_TAB};
	assign key_hit  = (key_q < clfe_pkg::KEY_LEN) && (rx_byte == clfe_pkg::key_char(key_q));
	assign brk_hit  = rx_byte == clfe_pkg::brk_char(brk_q);
	assign last     = rem_q[LW-1:1] == '0;

	// len * 10 + digit, saturate when it no longer fits
	assign prod    = ({4'b0, len_q} << 3) + ({4'b0, len_q} << 1)
	               + (LW+4)'(rx_byte[3:0]);
	assign len_dig = (prod[LW+3:LW] != 4'b0) ? '1 : prod[LW-1:0];

	always_comb begin
		in_payload_n = in_payload_q;
		brk_n        = brk_q;
		key_n        = key_q;
		key_try      = key_q;
		phase_n      = phase_q;
		len_n        = len_q;
		rem_n        = rem_q;
		have_len     = 1'b0;
		res          = '0;
		if (in_payload_q) begin
			if (rem_q != '0) begin
				rem_n = rem_q - LW'(1);
			end
			in_payload_n        = !last;
			res.produce         = 1'b1;
			res.payload_byte    = rx_byte;
			res.last_of_message = last;
		end else begin
			case (phase_q)
				PH_BLANK: begin
					if (is_digit) begin
						phase_n = PH_DIGIT;
						len_n   = len_dig;
					end else if (!is_blank) begin
						phase_n = PH_DONE;
					end
				end
				PH_DIGIT: begin
					if (is_digit) begin
						len_n = len_dig;
					end else begin
						phase_n = PH_DONE;
					end
				end
				default: ;
			endcase

			// search for the key until its first occurrence
			if (phase_n == PH_IDLE) begin
				if (key_hit) begin
					key_try = key_q + 4'd1;
				end else begin
					key_try = (rx_byte == clfe_pkg::key_char(4'd0)) ? 4'd1 : 4'd0;
				end
				if (key_try == clfe_pkg::KEY_LEN) begin
					phase_n = PH_BLANK;
					key_n   = 4'd0;
				end else begin
					key_n = key_try;
				end
			end

			if (brk_hit && brk_q == 2'd3) begin
				// end of header: if a key was seen, start the payload or report an empty message
				have_len = phase_n != PH_IDLE;
				if (have_len) begin
					if (len_n == '0) begin
						res.produce         = 1'b1;
						res.last_of_message = 1'b1;
						res.empty_message   = 1'b1;
					end else begin
						in_payload_n = 1'b1;
						rem_n        = len_n;
					end
				end
				brk_n   = 2'd0;
				key_n   = 4'd0;
				phase_n = PH_IDLE;
				len_n   = '0;
			end else if (brk_hit) begin
				brk_n = brk_q + 2'd1;
			end else begin
				brk_n = (rx_byte == clfe_pkg::CHAR_CR) ? 2'd1 : 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			brk_q        <= 2'd0;
			key_q        <= 4'd0;
			phase_q      <= PH_IDLE;
			len_q        <= '0;
			rem_q        <= '0;
		end else if (step) begin
			in_payload_q <= in_payload_n;
			brk_q        <= brk_n;
			key_q        <= key_n;
			phase_q      <= phase_n;
			len_q        <= len_n;
			rem_q        <= rem_n;
		end
	end

`ifndef SYNTHESIS
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> rem_q != '0)
		else $error("payload phase with zero bytes remaining");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		key_q < clfe_pkg::KEY_LEN)
		else $error("key match index past key length");

	a_len_without_key: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> len_q == '0)
		else $error("length value set before key was seen");

	a_empty_only_at_lf: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.empty_message |-> rx_byte == clfe_pkg::CHAR_LF && !in_payload_q)
		else $error("empty message not at header terminator");
`endif

endmodule

`default_nettype wire

@@ src/content_length_frame_extractor.sv @@
// Content-length frame extractor: byte input register, header scanner, result register.
// Depends on clfe_pkg and clfe_hdr_scan.
//
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) carries the framed stream, one byte
//   per transfer. Output channel (out_valid, out_stall, payload_byte,
//   last_of_message, empty_message) carries message body bytes; last_of_message
//   marks the final byte, and a header that declares length zero gives one
//   transfer with empty_message and last_of_message set and payload_byte zero.
//   Headers without a Content-Length key produce nothing.
// Path: a payload byte is taken into the input register at its input transfer and
//   into the result register when the scanner steps on it; a result held on the
//   output by out_stall delays that second step.
// Throughput: one byte per cycle while out_stall holds no result; the scanner
//   state update is a single combinational step between the two registers.
// Reset: arst_n clears both registers' valid bits and the scanner back to the
//   header phase with no partial match.
// Stall: while out_stall holds a result, the input register keeps the next byte
//   and in_stall rises; header bytes wait behind a held result as well.
`default_nettype none

module content_length_frame_extractor #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      payload_byte,
	output logic            last_of_message,
	output logic            empty_message
);

	logic              valid_s1;
	logic [7:0]        rx_byte_s1;
	logic              out_free, advance, in_take;
	clfe_pkg::result_t res;

	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	clfe_hdr_scan #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (rx_byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= advance && res.produce;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res.produce) begin
			payload_byte    <= res.payload_byte;
			last_of_message <= res.last_of_message;
			empty_message   <= res.empty_message;
		end
	end

`ifndef SYNTHESIS
	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_message |-> last_of_message && payload_byte == 8'h00)
		else $error("empty message result with body byte or no end mark");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a held result");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(rx_byte_s1))
		else $error("input register lost a byte while output was held");
`endif

endmodule

`default_nettype wire

@@ bench/tb_content_length_frame_extractor.sv @@
`timescale 1ns / 100ps
// Self-checking bench for content_length_frame_extractor: header-framed byte
// stream in, message body beats out, checked against a scoreboard that tracks
// the deframing state. Depends on clfe_pkg and the extractor RTL.

typedef enum logic [1:0] {
	LEN_ABSENT,
	LEN_BLANKS,
	LEN_DIGITS,
	LEN_DONE
} length_phase_t;

typedef enum int unsigned {
	IDLE_NONE,
	IDLE_SENDER,
	IDLE_RECEIVER,
	IDLE_BOTH
} idle_mode_t;

class deframer_scoreboard;
	localparam logic [8*15-1:0] KEY_TEXT = "Content-Length:";
	localparam longint unsigned LEN_MAX = 64'h0000_0000_FFFF_FFFF;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
	} body_beat_t;

	bit              in_payload;
	logic [1:0]      break_count;
	logic [3:0]      key_count;
	length_phase_t   len_phase;
	longint unsigned declared_len;
	longint unsigned body_left;
	body_beat_t      expected_body[$];
	int unsigned     mismatches;
	int unsigned     beats_checked;
	int unsigned     messages_closed;
	int unsigned     empty_seen;

	function new();
		in_payload      = 1'b0;
		break_count     = '0;
		key_count       = '0;
		len_phase       = LEN_ABSENT;
		declared_len    = 0;
		body_left       = 0;
		mismatches      = 0;
		beats_checked   = 0;
		messages_closed = 0;
		empty_seen      = 0;
	endfunction

	function logic [7:0] key_byte(int unsigned k);
		return KEY_TEXT[8*(14 - k) +: 8];
	endfunction

	// saturate instead of wrapping
	function void add_digit(logic [7:0] d);
		if (declared_len > (LEN_MAX - d) / 10) begin
			declared_len = LEN_MAX;
		end else begin
			declared_len = declared_len * 10 + d;
		end
	endfunction

	function void note_byte(logic [7:0] b);
		bit              is_digit;
		int unsigned     brk;
		logic [7:0]      brk_char;
		bit              had_key;
		longint unsigned len;
		is_digit = (b >= clfe_pkg::CHAR_D0) && (b <= clfe_pkg::CHAR_D9);

		// body bytes pass through unexamined
		if (in_payload) begin
			expected_body.push_back('{data: b, last: (body_left <= 1), empty: 1'b0});
			if (body_left <= 1) begin
				in_payload = 1'b0;
			end
			if (body_left > 0) begin
				body_left--;
			end
			return;
		end

		case (len_phase)
			LEN_BLANKS: begin
				if (is_digit) begin
					len_phase = LEN_DIGITS;
					add_digit(b - clfe_pkg::CHAR_D0);
				end else if (b != clfe_pkg::CHAR_SP && b != clfe_pkg::CHAR_TAB) begin
					len_phase = LEN_DONE;
				end
			end
			LEN_DIGITS: begin
				if (is_digit) begin
					add_digit(b - clfe_pkg::CHAR_D0);
				end else begin
					len_phase = LEN_DONE;
				end
			end
			default: begin
			end
		endcase

		// only the first key of a header counts
		if (len_phase == LEN_ABSENT) begin
			if (key_count < clfe_pkg::KEY_LEN && b == key_byte(key_count)) begin
				key_count++;
			end else begin
				key_count = (b == key_byte(0)) ? 4'd1 : 4'd0;
			end
			if (key_count >= clfe_pkg::KEY_LEN) begin
				len_phase = LEN_BLANKS;
				key_count = '0;
			end
		end

		brk_char = break_count[0] ? clfe_pkg::CHAR_LF : clfe_pkg::CHAR_CR;
		if (b == brk_char) begin
			brk = break_count + 1;
		end else begin
			brk = (b == clfe_pkg::CHAR_CR) ? 1 : 0;
		end
		if (brk >= 4) begin
			had_key      = (len_phase != LEN_ABSENT);
			len          = declared_len;
			break_count  = '0;
			key_count    = '0;
			len_phase    = LEN_ABSENT;
			declared_len = 0;
			if (had_key) begin
				if (len == 0) begin
					expected_body.push_back('{data: 8'h00, last: 1'b1, empty: 1'b1});
				end else begin
					in_payload = 1'b1;
					body_left  = len;
				end
			end
		end else begin
			break_count = brk[1:0];
		end
	endfunction

	function void check_result(logic [7:0] data, logic last, logic empty);
		body_beat_t want;
		beats_checked++;
		if (last === 1'b1) begin
			messages_closed++;
		end
		if (empty === 1'b1) begin
			empty_seen++;
		end
		if (expected_body.size() == 0) begin
			mismatches++;
			$error("unexpected transfer: payload_byte %0h last %0b empty %0b", data, last, empty);
			return;
		end
		want = expected_body.pop_front();
		if (data !== want.data) begin
			mismatches++;
			$error("payload_byte: expected %0h, actual %0h", want.data, data);
		end
		if (last !== want.last) begin
			mismatches++;
			$error("last_of_message: expected %0b, actual %0b", want.last, last);
		end
		if (empty !== want.empty) begin
			mismatches++;
			$error("empty_message: expected %0b, actual %0b", want.empty, empty);
		end
	endfunction

	function void flag_leftovers();
		if (expected_body.size() != 0) begin
			mismatches += expected_body.size();
			$error("%0d expected body beats never arrived", expected_body.size());
		end
	endfunction
endclass

module tb_content_length_frame_extractor;

	localparam int unsigned RANDOM_BYTES = 1450;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic       last_of_message;
	logic       empty_message;

	deframer_scoreboard sb = new();

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned bytes_sent;
	int unsigned cycle_count;

	content_length_frame_extractor DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.payload_byte    (payload_byte),
		.last_of_message (last_of_message),
		.empty_message   (empty_message)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receive side: check each transfer, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(payload_byte, last_of_message, empty_message);
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct  = 58;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct  = 0;
				recv_stall_pct = 58;
			end
			default: begin
				send_idle_pct  = 28;
				recv_stall_pct = 28;
			end
		endcase
	endtask

	// valid stays high across back-to-back transfers; hold payload while stalled
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	task automatic send_line_end();
		send_byte(clfe_pkg::CHAR_CR);
		send_byte(clfe_pkg::CHAR_LF);
	endtask

	task automatic send_blanks();
		repeat ($urandom_range(3)) begin
			send_byte($urandom_range(1) ? clfe_pkg::CHAR_SP : clfe_pkg::CHAR_TAB);
		end
	endtask

	// printable, non-empty, so it never closes the header on its own
	task automatic send_noise_line();
		repeat ($urandom_range(1, 12)) begin
			send_byte(8'($urandom_range(8'h21, 8'h7E)));
		end
		send_line_end();
	endtask

	task automatic send_length_line(input longint unsigned len);
		string digits;
		digits = $sformatf("%0d", len);
		if ($urandom_range(7) == 0) begin
			digits = {"00", digits};
		end
		send_text("Content-Length:");
		send_blanks();
		send_text(digits);
		send_line_end();
	endtask

	// pick a body length, mostly short
	function automatic longint unsigned pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10) begin
			return 0;
		end else if (r < 85) begin
			return 64'($urandom_range(1, 16));
		end else if (r < 97) begin
			return 64'($urandom_range(17, 64));
		end
		return 64'($urandom_range(65, 300));
	endfunction

	task automatic drain_body();
		logic [7:0] b;
		while (sb.in_payload) begin
			case ($urandom_range(7))
				0:       b = clfe_pkg::CHAR_CR;
				1:       b = clfe_pkg::CHAR_LF;
				2:       b = "C";
				default: b = 8'($urandom_range(255));
			endcase
			send_byte(b);
		end
	endtask

	task automatic send_random_message();
		int unsigned kind;
		kind = $urandom_range(99);
		repeat ($urandom_range(2)) begin
			send_noise_line();
		end
		if (kind < 72) begin
			send_length_line(pick_length());
		end else if (kind < 80) begin
			// key with no digits: letter ends the value as zero
			send_text("Content-Length:");
			send_blanks();
			send_byte(8'($urandom_range(8'h61, 8'h7A)));
			send_noise_line();
		end else if (kind < 86) begin
			send_length_line(pick_length());
			send_length_line({$urandom, $urandom});
		end else if (kind < 92) begin
			send_text("Content-Len");
			send_noise_line();
		end else begin
			repeat ($urandom_range(1, 24)) begin
				send_byte(8'($urandom_range(255)));
			end
		end
		if (kind < 92) begin
			repeat ($urandom_range(1)) begin
				send_noise_line();
			end
			send_line_end();
		end
		drain_body();
	endtask

	initial begin
		int unsigned directed_bytes;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		rx_byte   <= '0;
		set_idling(IDLE_NONE);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length gives one empty transfer
		send_text("Content-Length:0");
		send_line_end();
		send_line_end();

		// blanks and a tab before the value, extreme body bytes
		send_text("Content-Length: \t 3");
		send_line_end();
		send_line_end();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte("C");

		// no key: drop
		send_text("X-Note: hi");
		send_line_end();
		send_line_end();

		// key with no digits
		send_text("Content-Length:abc");
		send_line_end();
		send_line_end();

		// second key ignored; terminator inside the body passes through
		send_text("Content-Length: 4");
		send_line_end();
		send_text("Content-Length: 9");
		send_line_end();
		send_line_end();
		send_line_end();
		send_line_end();

		// digits after the value ends are ignored
		send_text("Content-Length:0002x7");
		send_line_end();
		send_line_end();
		send_text("Co");

		// partial key restarts, CR repeat in the terminator
		send_text("ContentContent-Length:1");
		send_byte(clfe_pkg::CHAR_CR);
		send_line_end();
		send_line_end();
		send_byte(8'h80);

		directed_bytes = bytes_sent;
		while (bytes_sent - directed_bytes < RANDOM_BYTES) begin
			set_idling(idle_mode_t'((bytes_sent - directed_bytes) * 4 / RANDOM_BYTES));
			send_random_message();
		end

		// oversized value saturates; the body outlasts the run
		set_idling(IDLE_BOTH);
		send_text("Content-Length: 99999999999");
		send_line_end();
		send_line_end();
		repeat (40) begin
			send_byte(8'($urandom_range(255)));
		end
		in_valid <= 1'b0;

		while (sb.expected_body.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flag_leftovers();

		$display("Covered %0d input bytes, %0d body transfers checked, %0d messages closed.",
			bytes_sent, sb.beats_checked, sb.messages_closed);
		$display("Empty messages: %0d; idling ran none, sender, receiver and both.",
			sb.empty_seen);
		if (sb.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
